// File: sv/sqd_pkg.sv
package sqd_pkg;

    localparam int ACTION_W  = 3;
    localparam int ARRIVAL_W = 8;
    localparam int GROUP_W   = 8;
    localparam int QI_W      = 4;
    localparam int POS_W     = 16;
    localparam int CHOSEN_W  = 4;
    localparam int STATUS_W  = 3;
    localparam int WAIT_W    = 24;
    localparam int TOTAL_W   = 20;
    localparam int ACTIVE_W  = 5;
    localparam int SERVICE_W = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam int S_FIELDS_W = ACTION_W + ARRIVAL_W + GROUP_W + QI_W + POS_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = CHOSEN_W + STATUS_W + WAIT_W + WAIT_W + TOTAL_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_REBAL  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SHIFT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_LAST = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MOVED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BEST     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_POS  = 3'd4;

    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SERVICE = 1'b1;

    localparam logic [WAIT_W-1:0]  WAIT_MAX  = 24'hFFFFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INS,
        WR_MIN_INC,
        WR_TGT_DEC,
        WR_TICK,
        WR_SHIFT_DST,
        WR_SHIFT_SRC
    } t_wr;

    typedef enum logic [1:0] {
        MUL_POS,
        MUL_RD,
        MUL_DST
    } t_mul;

    typedef struct packed {
        logic                load;
        logic                scan_start;
        logic                item_inc;
        logic                remain_dec;
        logic                chosen_min;
        logic                status_set;
        logic [STATUS_W-1:0] status_code;
        t_wr                 wr_sel;
        logic                mul_go;
        t_mul                mul_sel;
        logic                wcur_ld;
        logic                wnew_ld;
        logic                out_load;
    } t_cmd;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                scan_done;
        logic                remain_zero;
        logic                remain_last;
        logic                item_last;
        logic                qi_ok;
        logic                pos_lt;
        logic                pos_eq;
        logic                move_ok;
        logic                min_lt_cap;
        logic                out_free;
    } t_sts;

endpackage

// File: sv/sqd_ram.sv
module sqd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/sqd_dp.sv
module sqd_dp
    import sqd_pkg::*;
#(
    parameter int NUM_QUEUES  = 16,
    parameter int COUNT_WIDTH = 16,
    localparam int QW = $clog2(NUM_QUEUES),
    localparam int NW = $clog2(NUM_QUEUES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [NW-1:0]        i_n,
    input  logic [SERVICE_W-1:0] i_service,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata
);

    localparam int CW   = COUNT_WIDTH;
    localparam int CW1  = CW + 1;
    localparam int QIW  = (QW > QI_W) ? QW : QI_W;
    localparam int CMPW = (NW > QIW) ? NW : QIW;
    localparam int MW   = (CW > POS_W) ? CW : POS_W;
    localparam int PW   = MW + SERVICE_W;
    localparam int SW   = ((CW > TOTAL_W) ? CW : TOTAL_W) + 1;

    logic [ACTION_W-1:0]  r_action;
    logic [GROUP_W-1:0]   r_group;
    logic [QI_W-1:0]      r_qi;
    logic [POS_W-1:0]     r_pos;
    logic [ARRIVAL_W-1:0] r_remain;
    logic [QW-1:0]        r_item;
    logic [QW-1:0]        r_chosen;
    logic [STATUS_W-1:0]  r_status;
    logic [WAIT_W-1:0]    r_wcur;
    logic [WAIT_W-1:0]    r_wnew;
    logic [PW-1:0]        r_prod;
    logic                 r_scan_active;
    logic [NW-1:0]        r_scan_idx;
    logic                 r_scan_dv;
    logic [QW-1:0]        r_scan_didx;
    logic [CW-1:0]        r_min_val;
    logic [QW-1:0]        r_min_idx;
    logic [CW-1:0]        r_cap;
    logic [TOTAL_W-1:0]   r_sum;
    logic [QW-1:0]        r_raddr_q;
    logic [NUM_QUEUES-1:0] r_vld;
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    logic [CW-1:0]      unit;
    logic [QIW-1:0]     qi_ext;
    logic [QW-1:0]      tgt;
    logic [QW-1:0]      rd_addr;
    logic [CW-1:0]      ram_q;
    logic [CW-1:0]      rd_data;
    logic [CW1-1:0]     ins_sum;
    logic [CW-1:0]      ins_val;
    logic [CW-1:0]      dst_val;
    logic               wr_en;
    logic [QW-1:0]      wr_addr;
    logic [CW-1:0]      wr_data;
    logic [MW-1:0]      operand;
    logic [WAIT_W-1:0]  prod_sat;
    logic [SW-1:0]      sum_ext;
    logic [TOTAL_W-1:0] n_sum;
    logic [CHOSEN_W-1:0] chosen_out;
    logic [QIW-1:0]     chosen_ext;
    logic               out_free;

    assign unit    = (r_group == '0) ? CW'(1) : CW'(r_group);
    assign qi_ext  = QIW'(r_qi);
    assign tgt     = (r_action == ACT_SHIFT || r_action == ACT_QUERY) ? qi_ext[QW-1:0] : r_item;
    assign rd_addr = r_scan_active ? r_scan_idx[QW-1:0] : tgt;
    assign rd_data = r_vld[r_raddr_q] ? ram_q : '0;
    assign ins_sum = CW1'(r_min_val) + CW1'(unit);
    assign ins_val = ins_sum[CW] ? {CW{1'b1}} : ins_sum[CW-1:0];
    assign dst_val = r_min_val + unit;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_min_idx;
        wr_data = ins_val;
        case (i_cmd.wr_sel)
            WR_INS: begin
                wr_en = 1'b1;
            end
            WR_MIN_INC: begin
                wr_en   = 1'b1;
                wr_data = r_min_val + CW'(1);
            end
            WR_TGT_DEC: begin
                wr_en   = 1'b1;
                wr_addr = tgt;
                wr_data = r_cap - CW'(1);
            end
            WR_TICK: begin
                wr_en   = (rd_data != '0);
                wr_addr = tgt;
                wr_data = rd_data - CW'(1);
            end
            WR_SHIFT_DST: begin
                wr_en   = 1'b1;
                wr_data = dst_val;
            end
            WR_SHIFT_SRC: begin
                wr_en   = 1'b1;
                wr_addr = tgt;
                wr_data = r_cap - unit;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_POS: operand = MW'(r_pos);
            MUL_RD:  operand = MW'(rd_data);
            MUL_DST: operand = MW'(dst_val);
            default: operand = '0;
        endcase
    end

    assign prod_sat   = (r_prod > PW'(WAIT_MAX)) ? WAIT_MAX : r_prod[WAIT_W-1:0];
    assign sum_ext    = SW'(r_sum) + SW'(rd_data);
    assign n_sum      = (sum_ext > SW'(TOTAL_MAX)) ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
    assign chosen_ext = QIW'(r_chosen);
    assign chosen_out = chosen_ext[CHOSEN_W-1:0];
    assign out_free   = !r_m_valid || i_m_tready;

    sqd_ram #(
        .WIDTH (CW),
        .DEPTH (NUM_QUEUES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_active <= 1'b0;
            r_scan_dv     <= 1'b0;
            r_vld         <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_scan_dv <= r_scan_active;
            if (i_cmd.scan_start) begin
                r_scan_active <= 1'b1;
            end else if (r_scan_active && r_scan_idx == i_n - NW'(1)) begin
                r_scan_active <= 1'b0;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr_q   <= rd_addr;
        r_scan_didx <= r_scan_idx[QW-1:0];
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
            r_sum      <= '0;
        end else if (r_scan_active) begin
            r_scan_idx <= r_scan_idx + NW'(1);
        end
        if (r_scan_dv) begin
            if (r_scan_didx == '0 || rd_data <= r_min_val) begin
                r_min_val <= rd_data;
                r_min_idx <= r_scan_didx;
            end
            r_sum <= n_sum;
            if (r_scan_didx == tgt) begin
                r_cap <= rd_data;
            end
        end
        if (i_cmd.load) begin
            r_action <= i_s_tdata[2:0];
            r_remain <= i_s_tdata[10:3];
            r_group  <= i_s_tdata[18:11];
            r_qi     <= i_s_tdata[22:19];
            r_pos    <= i_s_tdata[38:23];
            r_item   <= '0;
            r_chosen <= '0;
            r_status <= ST_DONE;
            r_wcur   <= '0;
            r_wnew   <= '0;
        end else begin
            if (i_cmd.item_inc) begin
                r_item <= r_item + QW'(1);
            end
            if (i_cmd.remain_dec) begin
                r_remain <= r_remain - ARRIVAL_W'(1);
            end
            if (i_cmd.chosen_min) begin
                r_chosen <= r_min_idx;
            end
            if (i_cmd.status_set) begin
                r_status <= i_cmd.status_code;
            end
            if (i_cmd.wcur_ld) begin
                r_wcur <= prod_sat;
            end
            if (i_cmd.wnew_ld) begin
                r_wnew <= prod_sat;
            end
        end
        if (i_cmd.mul_go) begin
            r_prod <= PW'(i_service) * PW'(operand);
        end
        if (i_cmd.out_load) begin
            r_m_data <= {{M_PAD_W{1'b0}}, r_sum, r_wnew, r_wcur, r_status, chosen_out};
        end
    end

    assign o_sts.action      = r_action;
    assign o_sts.scan_done   = !r_scan_active && !r_scan_dv;
    assign o_sts.remain_zero = (r_remain == '0);
    assign o_sts.remain_last = (r_remain == ARRIVAL_W'(1));
    assign o_sts.item_last   = (NW'(r_item) == i_n - NW'(1));
    assign o_sts.qi_ok       = (CMPW'(r_qi) < CMPW'(i_n));
    assign o_sts.pos_lt      = (MW'(r_pos) < MW'(r_cap));
    assign o_sts.pos_eq      = (MW'(r_pos) == MW'(r_cap));
    assign o_sts.move_ok     = (CW1'(r_min_val) + CW1'(r_group)) < CW1'(r_cap);
    assign o_sts.min_lt_cap  = (r_min_val < r_cap);
    assign o_sts.out_free    = out_free;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> !r_scan_active && !r_scan_dv)
        else $error("counter write during scan");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_active |-> r_scan_idx < i_n)
        else $error("scan index beyond active queues");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result overwritten before taken");

endmodule

// File: sv/sqd_ctrl.sv
module sqd_ctrl
    import sqd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_SWAIT,
        S_INS_WR,
        S_RB_CHK,
        S_RB_DEC,
        S_TK_RD,
        S_TK_WR,
        S_SH_CHK,
        S_SH_WC,
        S_SH_DST,
        S_SH_SRC,
        S_Q_RD,
        S_Q_MUL,
        S_Q_WC,
        S_TOT,
        S_TWAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.action)
                    ACT_INSERT: n_state = i_sts.remain_zero ? S_TOT : S_SCAN;
                    ACT_TICK:   n_state = S_TK_RD;
                    ACT_REBAL:  n_state = S_SCAN;
                    ACT_SHIFT: begin
                        if (i_sts.qi_ok) begin
                            n_state = S_SCAN;
                        end else begin
                            cmd.status_set  = 1'b1;
                            cmd.status_code = ST_BAD_POS;
                            n_state         = S_TOT;
                        end
                    end
                    ACT_QUERY:  n_state = i_sts.qi_ok ? S_Q_RD : S_TOT;
                    default:    n_state = S_TOT;
                endcase
            end
            S_SCAN: begin
                cmd.scan_start = 1'b1;
                n_state        = S_SWAIT;
            end
            S_SWAIT: begin
                if (i_sts.scan_done) begin
                    case (i_sts.action)
                        ACT_INSERT: n_state = S_INS_WR;
                        ACT_REBAL:  n_state = S_RB_CHK;
                        default:    n_state = S_SH_CHK;
                    endcase
                end
            end
            S_INS_WR: begin
                cmd.wr_sel     = WR_INS;
                cmd.chosen_min = 1'b1;
                cmd.remain_dec = 1'b1;
                n_state        = i_sts.remain_last ? S_TOT : S_SCAN;
            end
            S_RB_CHK: begin
                if (i_sts.min_lt_cap) begin
                    cmd.wr_sel = WR_MIN_INC;
                    n_state    = S_RB_DEC;
                end else begin
                    cmd.item_inc = 1'b1;
                    n_state      = i_sts.item_last ? S_TOT : S_SCAN;
                end
            end
            S_RB_DEC: begin
                cmd.wr_sel   = WR_TGT_DEC;
                cmd.item_inc = 1'b1;
                n_state      = i_sts.item_last ? S_TOT : S_SCAN;
            end
            S_TK_RD: begin
                n_state = S_TK_WR;
            end
            S_TK_WR: begin
                cmd.wr_sel   = WR_TICK;
                cmd.item_inc = 1'b1;
                n_state      = i_sts.item_last ? S_TOT : S_TK_RD;
            end
            S_SH_CHK: begin
                if (!i_sts.pos_lt && !i_sts.pos_eq) begin
                    cmd.status_set  = 1'b1;
                    cmd.status_code = ST_BAD_POS;
                    n_state         = S_TOT;
                end else begin
                    cmd.mul_go  = 1'b1;
                    cmd.mul_sel = MUL_POS;
                    n_state     = S_SH_WC;
                end
            end
            S_SH_WC: begin
                cmd.wcur_ld = 1'b1;
                if (i_sts.pos_lt) begin
                    cmd.status_set  = 1'b1;
                    cmd.status_code = ST_NOT_LAST;
                    n_state         = S_TOT;
                end else if (i_sts.move_ok) begin
                    n_state = S_SH_DST;
                end else begin
                    cmd.status_set  = 1'b1;
                    cmd.status_code = ST_BEST;
                    n_state         = S_TOT;
                end
            end
            S_SH_DST: begin
                cmd.wr_sel      = WR_SHIFT_DST;
                cmd.chosen_min  = 1'b1;
                cmd.status_set  = 1'b1;
                cmd.status_code = ST_MOVED;
                cmd.mul_go      = 1'b1;
                cmd.mul_sel     = MUL_DST;
                n_state         = S_SH_SRC;
            end
            S_SH_SRC: begin
                cmd.wr_sel  = WR_SHIFT_SRC;
                cmd.wnew_ld = 1'b1;
                n_state     = S_TOT;
            end
            S_Q_RD: begin
                n_state = S_Q_MUL;
            end
            S_Q_MUL: begin
                cmd.mul_go  = 1'b1;
                cmd.mul_sel = MUL_RD;
                n_state     = S_Q_WC;
            end
            S_Q_WC: begin
                cmd.wcur_ld = 1'b1;
                n_state     = S_TOT;
            end
            S_TOT: begin
                cmd.scan_start = 1'b1;
                n_state        = S_TWAIT;
            end
            S_TWAIT: begin
                if (i_sts.scan_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_state == S_DISP)
        else $error("request accepted but not dispatched");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (cmd.wr_sel == WR_NONE && !cmd.scan_start && !cmd.out_load))
        else $error("datapath command while idle");

    a_scan_wait_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SWAIT || r_state == S_TWAIT) && !i_sts.scan_done)
        |=> r_state == $past(r_state))
        else $error("left scan wait before scan finished");

endmodule

// File: sv/shortest_queue_dispatcher_top.sv
// one request at a time; s_tready is high only while no request is in work
// insert: a scan and a counter write per arrival, then the total scan before m_tvalid
// serve tick: a read and a write per active queue; rebalance: a scan per queue plus two writes per unit moved
// shift: only the total scan when out of range, else scan, wait product and move; wait query: read and product
// each scan goes through the single read port of the counter memory, one counter a cycle
// synchronous reset clears all counters through valid bits, active queues 16, service time 1
module shortest_queue_dispatcher_top
    import sqd_pkg::*;
#(
    parameter int NUM_QUEUES  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // action, arrivals, group_size, queue_index, position
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // chosen_queue, status, wait_current, wait_new, total_occupancy
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int NW  = $clog2(NUM_QUEUES + 1);
    localparam int AXW = (NW > ACTIVE_W) ? NW : ACTIVE_W;

    logic [ACTIVE_W-1:0]  r_active;
    logic [SERVICE_W-1:0] r_service;
    logic [AXW-1:0]       active_ext;
    logic [NW-1:0]        eff_n;
    t_cmd                 cmd;
    t_sts                 sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= ACTIVE_W'(16);
            r_service <= SERVICE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ACTIVE:  r_active  <= i_cfg_wdata[ACTIVE_W-1:0];
                CFG_SERVICE: r_service <= i_cfg_wdata[SERVICE_W-1:0];
                default:     r_service <= r_service;
            endcase
        end
    end

    assign active_ext = AXW'(r_active);

    always_comb begin
        if (active_ext == '0) begin
            eff_n = NW'(1);
        end else if (active_ext > AXW'(NUM_QUEUES)) begin
            eff_n = NW'(NUM_QUEUES);
        end else begin
            eff_n = NW'(active_ext);
        end
    end

    sqd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sqd_dp #(
        .NUM_QUEUES  (NUM_QUEUES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_n        (eff_n),
        .i_service  (r_service),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

endmodule

// File: test/sqd_checker.sv
module sqd_checker
    import sqd_pkg::*;
#(
    parameter int NUM_QUEUES  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    // action, arrivals, group_size, queue_index, position
    input  logic [S_TDATA_W-1:0]              s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    // chosen_queue, status, wait_current, wait_new, total_occupancy
    input  logic [M_TDATA_W-1:0]              m_tdata,
    input  logic                              i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]             i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]             i_cfg_wdata,
    output logic [31:0]                       o_fail_count,
    output logic [31:0]                       o_pending,
    output logic [NUM_QUEUES*COUNT_WIDTH-1:0] o_queue_counts
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;

    typedef struct packed {
        logic [POS_W-1:0]     position;
        logic [QI_W-1:0]      queue_index;
        logic [GROUP_W-1:0]   group_size;
        logic [ARRIVAL_W-1:0] arrivals;
        logic [ACTION_W-1:0]  action;
    } t_request;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [WAIT_W-1:0]   wait_new;
        logic [WAIT_W-1:0]   wait_cur;
        logic [STATUS_W-1:0] status;
        logic [CHOSEN_W-1:0] chosen;
    } t_outcome;

    logic [COUNT_WIDTH-1:0] queue_count [NUM_QUEUES];
    logic [ACTIVE_W-1:0]    active_cfg;
    logic [SERVICE_W-1:0]   service_cfg;
    t_outcome               expected_results [$];
    int                     mismatches;

    // lowest counter among the active queues, ties to the highest index
    function automatic int unsigned shortest_queue(int unsigned n);
        int unsigned best;
        best = 0;
        for (int unsigned j = 1; j < n; j++) begin
            if (queue_count[j] <= queue_count[best]) best = j;
        end
        return best;
    endfunction

    function automatic logic [WAIT_W-1:0] scaled_wait(longint unsigned v);
        longint unsigned w;
        w = 64'(service_cfg) * v;
        return (w > 64'(WAIT_MAX)) ? WAIT_MAX : w[WAIT_W-1:0];
    endfunction

    function automatic string outcome_text(t_outcome o);
        return $sformatf("chosen=%0d status=%0d wcur=%0d wnew=%0d total=%0d",
                         o.chosen, o.status, o.wait_cur, o.wait_new, o.total);
    endfunction

    function automatic t_outcome dispatch_event(t_request rq);
        t_outcome        r;
        int unsigned     n;
        int unsigned     unit;
        int unsigned     a;
        int unsigned     c;
        longint unsigned sum;
        r = '0;
        n = (active_cfg == '0) ? 1
          : ((32'(active_cfg) > NUM_QUEUES) ? NUM_QUEUES : 32'(active_cfg));
        unit = (rq.group_size == '0) ? 1 : 32'(rq.group_size);
        case (rq.action)
            ACT_INSERT: begin
                for (int unsigned i = 0; i < 32'(rq.arrivals); i++) begin
                    a = shortest_queue(n);
                    if (COUNT_MAX - 64'(queue_count[a]) < 64'(unit))
                        queue_count[a] = COUNT_WIDTH'(COUNT_MAX);
                    else
                        queue_count[a] = queue_count[a] + COUNT_WIDTH'(unit);
                    r.chosen = CHOSEN_W'(a);
                end
            end
            ACT_TICK: begin
                for (int unsigned i = 0; i < n; i++) begin
                    if (queue_count[i] != '0)
                        queue_count[i] = queue_count[i] - COUNT_WIDTH'(1);
                end
            end
            ACT_REBAL: begin
                for (int unsigned i = 0; i < n; i++) begin
                    a = shortest_queue(n);
                    if (queue_count[a] < queue_count[i]) begin
                        queue_count[a] = queue_count[a] + COUNT_WIDTH'(1);
                        queue_count[i] = queue_count[i] - COUNT_WIDTH'(1);
                    end
                end
            end
            ACT_SHIFT: begin
                if (32'(rq.queue_index) >= n) begin
                    r.status = ST_BAD_POS;
                end else begin
                    c = 32'(queue_count[rq.queue_index]);
                    if (32'(rq.position) < c) begin
                        r.status = ST_NOT_LAST;
                        r.wait_cur = scaled_wait(64'(rq.position));
                    end else if (32'(rq.position) == c) begin
                        r.wait_cur = scaled_wait(64'(rq.position));
                        a = shortest_queue(n);
                        if (64'(queue_count[a]) + 64'(rq.group_size) < 64'(c)) begin
                            queue_count[a] = queue_count[a] + COUNT_WIDTH'(unit);
                            queue_count[rq.queue_index] =
                                queue_count[rq.queue_index] - COUNT_WIDTH'(unit);
                            r.status = ST_MOVED;
                            r.chosen = CHOSEN_W'(a);
                            r.wait_new = scaled_wait(64'(queue_count[a]));
                        end else begin
                            r.status = ST_BEST;
                        end
                    end else begin
                        r.status = ST_BAD_POS;
                    end
                end
            end
            ACT_QUERY: begin
                if (32'(rq.queue_index) < n)
                    r.wait_cur = scaled_wait(64'(queue_count[rq.queue_index]));
            end
            default: begin
            end
        endcase
        sum = 0;
        for (int unsigned i = 0; i < n; i++) sum += 64'(queue_count[i]);
        r.total = (sum > 64'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_QUEUES; j++) queue_count[j] = '0;
            active_cfg = ACTIVE_W'(16);
            service_cfg = SERVICE_W'(1);
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = t_outcome'(m_tdata[M_FIELDS_W-1:0]);
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with no request waiting: %s",
                                 $realtime, outcome_text(got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.chosen !== want.chosen || got.status !== want.status ||
                        got.wait_cur !== want.wait_cur || got.wait_new !== want.wait_new ||
                        got.total !== want.total) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: mismatch exp %s", $realtime, outcome_text(want));
                            $display("%0t:          got %s", $realtime, outcome_text(got));
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACTIVE:  active_cfg = i_cfg_wdata[ACTIVE_W-1:0];
                    CFG_SERVICE: service_cfg = i_cfg_wdata[SERVICE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(dispatch_event(t_request'(s_tdata[S_FIELDS_W-1:0])));
        end
        o_fail_count <= 32'(mismatches);
        o_pending <= 32'(expected_results.size());
        for (int j = 0; j < NUM_QUEUES; j++)
            o_queue_counts[j*COUNT_WIDTH +: COUNT_WIDTH] <= queue_count[j];
    end

endmodule

// File: test/testbench.sv
module testbench
    import sqd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = 16;
    localparam int CW = 16;
    localparam int RANDOM_REQUESTS = 1900;
    localparam int PHASES = 6;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [ACTION_W-1:0] ACT_LAST_CODE = '1;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    logic [31:0]           fail_count;
    logic [31:0]           pending;
    logic [NQ*CW-1:0]      queue_counts;
    int                    sender_idle_pct = 0;
    int                    receiver_idle_pct = 0;
    int                    cycle_count = 0;

    shortest_queue_dispatcher_top #(
        .NUM_QUEUES  (NQ),
        .COUNT_WIDTH (CW)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    sqd_checker #(
        .NUM_QUEUES  (NQ),
        .COUNT_WIDTH (CW)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_queue_counts (queue_counts)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int unsigned count_of(int q);
        return 32'(queue_counts[q*CW +: CW]);
    endfunction

    // returns after acceptance, once the predicted counters are visible
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [ARRIVAL_W-1:0] arr,
                                input logic [GROUP_W-1:0] grp,
                                input logic [QI_W-1:0] qi,
                                input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < sender_idle_pct) @(posedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W-S_FIELDS_W){1'b0}}, pos, qi, grp, arr, act};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] active_w [PHASES];
        logic [CFG_DATA_W-1:0] service_w [PHASES];
        logic [ACTION_W-1:0]   act;
        logic [ARRIVAL_W-1:0]  arr;
        logic [GROUP_W-1:0]    grp;
        logic [QI_W-1:0]       qi;
        logic [POS_W-1:0]      pos;
        int                    eff_n;
        int                    r;
        int unsigned           c;

        active_w = '{8'd16, 8'd7, 8'd31, 8'd2, 8'hF0, 8'd11};
        service_w = '{8'd3, 8'd0, 8'd255, 8'($urandom), 8'd128, 8'd1};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty bank at reset settings
        send_request(ACT_QUERY, 8'd0, 8'd0, 4'd0, 16'd0);
        send_request(ACT_TICK, 8'd0, 8'd0, 4'd0, 16'd0);
        send_request(ACT_REBAL, 8'd0, 8'd0, 4'd0, 16'd0);
        send_request(ACT_INSERT, 8'd0, 8'd5, 4'd0, 16'd0);
        // single persons, ties go to the top queues
        send_request(ACT_INSERT, 8'd3, 8'd0, 4'd0, 16'd0);
        send_request(ACT_INSERT, 8'd40, 8'd2, 4'd0, 16'd0);
        send_request(ACT_SHIFT, 8'd0, 8'd0, 4'd3, POS_W'(count_of(3)));
        send_request(ACT_SHIFT, 8'd0, 8'd1, 4'd5, POS_W'(count_of(5) - 1));
        send_request(ACT_SHIFT, 8'd0, 8'd1, 4'd6, POS_W'(count_of(6) + 1));
        send_request(ACT_SHIFT, 8'd0, 8'd255, 4'd7, POS_W'(count_of(7)));
        send_request(ACT_INSERT, 8'd6, 8'd200, 4'd0, 16'd0);
        send_request(ACT_REBAL, 8'd0, 8'd0, 4'd0, 16'd0);
        send_request(ACT_SHIFT, 8'd0, 8'd0, 4'd15, 16'hFFFF);
        send_request(ACT_QUERY, 8'd0, 8'd0, 4'd15, 16'd0);
        for (int u = int'(ACT_QUERY) + 1; u <= int'(ACT_LAST_CODE); u++)
            send_request(ACTION_W'(u), 8'($urandom), 8'($urandom), 4'($urandom), 16'($urandom));
        send_request(ACT_TICK, 8'd0, 8'd0, 4'd0, 16'd0);

        // single queue, upper register bits ignored, counter saturation
        wait_idle();
        write_register(CFG_SERVICE, 8'd255);
        write_register(CFG_ACTIVE, 8'hE1);
        send_request(ACT_QUERY, 8'd0, 8'd0, 4'd1, 16'd0);
        send_request(ACT_SHIFT, 8'd0, 8'd0, 4'd1, 16'd0);
        send_request(ACT_INSERT, 8'd255, 8'd255, 4'd0, 16'd0);
        send_request(ACT_INSERT, 8'd255, 8'd255, 4'd0, 16'd0);
        send_request(ACT_SHIFT, 8'd0, 8'd0, 4'd0, POS_W'(count_of(0)));
        send_request(ACT_QUERY, 8'd0, 8'd0, 4'd0, 16'd0);

        // zero active queues behaves as one
        wait_idle();
        write_register(CFG_ACTIVE, 8'd0);
        send_request(ACT_QUERY, 8'd0, 8'd0, 4'd0, 16'd0);

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            write_register(CFG_ACTIVE, active_w[p]);
            write_register(CFG_SERVICE, service_w[p]);
            eff_n = int'(active_w[p][ACTIVE_W-1:0]);
            if (eff_n == 0) eff_n = 1;
            if (eff_n > NQ) eff_n = NQ;
            case (p / 2)
                0: begin
                    sender_idle_pct = 32;
                    receiver_idle_pct <= 69;
                end
                1: begin
                    sender_idle_pct = 69;
                    receiver_idle_pct <= 32;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct <= 0;
                end
            endcase
            for (int k = 0; k < RANDOM_REQUESTS / PHASES; k++) begin
                arr = 8'($urandom);
                grp = 8'($urandom);
                qi = 4'($urandom);
                pos = 16'($urandom);
                r = $urandom_range(99);
                if (r < 30) begin
                    act = ACT_INSERT;
                    r = $urandom_range(99);
                    if (r < 85) arr = ARRIVAL_W'($urandom_range(0, 6));
                    else if (r < 98) arr = ARRIVAL_W'($urandom_range(0, 40));
                    if ($urandom_range(99) < 80) grp = GROUP_W'($urandom_range(0, 4));
                end else if (r < 45) begin
                    act = ACT_TICK;
                end else if (r < 55) begin
                    act = ACT_REBAL;
                end else if (r < 85) begin
                    act = ACT_SHIFT;
                    if ($urandom_range(99) < 85) qi = QI_W'($urandom_range(0, eff_n - 1));
                    if ($urandom_range(99) < 60) grp = GROUP_W'($urandom_range(0, 3));
                    c = count_of(int'(qi));
                    r = $urandom_range(99);
                    if (r < 60) pos = POS_W'(c);
                    else if (r < 75) pos = (c == 0) ? 16'd0 : POS_W'($urandom_range(0, c - 1));
                    else if (r < 90) pos = (c >= 65532) ? 16'hFFFF
                                                        : POS_W'(c + 1 + $urandom_range(0, 3));
                end else if (r < 95) begin
                    act = ACT_QUERY;
                    if ($urandom_range(99) < 85) qi = QI_W'($urandom_range(0, eff_n - 1));
                end else begin
                    act = ACTION_W'($urandom_range(int'(ACT_QUERY) + 1, int'(ACT_LAST_CODE)));
                end
                send_request(act, arr, grp, qi, pos);
            end
        end

        wait_idle();
        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
